/* hw/rtl/olpd_pkg.sv */
// Package for the ordered list core: opcode and status codes, control struct.
// No dependencies.
`default_nettype none
package olpd_pkg;
   localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
   localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
   localparam logic [1:0] OP_DELETE     = 2'd2;
   localparam logic [1:0] OP_CLEAR      = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   // free-slot finder request
   typedef struct packed {
      logic start;
   } find_req_type;
endpackage
`default_nettype wire

/* hw/rtl/ordered_list_push_delete_core.sv */
// Ordered list core: doubly linked list in a slot pool, push/delete/clear.
// Depends on olpd_pkg and olpd_free_find.
//
// Usage:
//   req_ channel carries one command word: tdata = {value, opcode}
//   (opcode bits 1:0, value bits 33:2, zero padded to 40 bits).
//   rsp_ channel returns one word per command: tdata = {slot_used,
//   entry_total, status} (status 1:0, entry_total 8:2, slot_used 14:9).
//   Commands run one at a time. A push raises rsp_tvalid once the
//   free-map search, 8 slots per cycle, has found a slot or reached the
//   end and a found slot is linked in. A delete walks at most CAPACITY
//   list entries, one read of the link/value memories (S_RD) and one
//   compare (S_CMP) for each, then relinks (S_FIXP, S_FIXN) and registers
//   the result (S_OUT). Clear, and a delete on an empty list, go to S_OUT.
//   Reset empties the list at once: the free map, head, tail and count are
//   flip-flops; the link and value memories are never cleared and only
//   linked entries are read.
//   The result waits in an output register; while rsp_tready is low the
//   block holds it and does not take a new command.
`default_nettype none
module ordered_list_push_delete_core
   import olpd_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // opcode[1:0], value[33:2]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // status[1:0], entry_total[8:2], slot_used[14:9]
);
   localparam int SW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam logic [LW-1:0] NIL = LW'(CAPACITY);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_FIND  = 8'b00000010,
      S_PLINK = 8'b00000100,
      S_RD    = 8'b00001000,
      S_CMP   = 8'b00010000,
      S_FIXP  = 8'b00100000,
      S_FIXN  = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   // memories
   logic [VALUE_BITS-1:0] val_mem [CAPACITY];
   logic [LW-1:0]         fwd_mem [CAPACITY];
   logic [LW-1:0]         bwd_mem [CAPACITY];
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [LW-1:0]         fwd_rd_ff, bwd_rd_ff;

   state_type             state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [LW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [LW-1:0]         count_ff, count_in;
   logic [CAPACITY-1:0]   free_ff, free_in;
   logic [LW-1:0]         cur_ff, cur_in;
   logic [LW-1:0]         steps_ff, steps_in;
   logic [SW-1:0]         new_ff, new_in;
   logic [1:0]            st_ff, st_in;
   logic [5:0]            used_ff, used_in;
   logic                  rv_ff, rv_in;

   // memory write/read controls
   logic                  rd_en;
   logic [SW-1:0]         rd_addr;
   logic                  wv_en, wf_en, wb_en;
   logic [SW-1:0]         wv_addr, wf_addr, wb_addr;
   logic [LW-1:0]         wf_data, wb_data;

   find_req_type          ff_req;
   logic                  ff_done, ff_found;
   logic [SW-1:0]         ff_slot;

   olpd_free_find #(.CAPACITY(CAPACITY)) u_find (
      .clock(clock), .reset(reset), .req(ff_req), .free_map(free_ff),
      .done(ff_done), .found(ff_found), .slot(ff_slot)
   );

   assign req_tready = state_ff == S_IDLE && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {1'b0, used_ff, 7'(count_ff), st_ff};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      val_in   = val_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      free_in  = free_ff;
      cur_in   = cur_ff;
      steps_in = steps_ff;
      new_in   = new_ff;
      st_in    = st_ff;
      used_in  = used_ff;
      rv_in    = rv_ff;
      ff_req.start = 1'b0;
      rd_en = 1'b0;   rd_addr = cur_ff[SW-1:0];
      wv_en = 1'b0;   wv_addr = new_ff;
      wf_en = 1'b0;   wf_addr = new_ff;   wf_data = NIL;
      wb_en = 1'b0;   wb_addr = new_ff;   wb_data = NIL;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in  = req_tdata[1:0];
               val_in = VALUE_BITS'($signed(req_tdata[33:2]));
               st_in  = ST_DONE;
               used_in = '0;
               case (req_tdata[1:0])
                  OP_PUSH_BACK, OP_PUSH_FRONT: begin
                     ff_req.start = 1'b1;
                     state_in = S_FIND;
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY;
                        state_in = S_OUT;
                     end else begin
                        st_in = ST_MISSING;
                        cur_in = head_ff;
                        steps_in = '0;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     if (count_ff == '0) st_in = ST_EMPTY;
                     free_in  = '1;
                     head_in  = NIL;
                     tail_in  = NIL;
                     count_in = '0;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_FIND: begin
            if (ff_done) begin
               if (!ff_found) begin
                  st_in = ST_FULL;
                  state_in = S_OUT;
               end else begin
                  new_in = ff_slot;
                  wv_en = 1'b1; wv_addr = ff_slot;
                  wf_en = 1'b1; wf_addr = ff_slot;
                  wb_en = 1'b1; wb_addr = ff_slot;
                  free_in[ff_slot] = 1'b0;
                  used_in = 6'(ff_slot);
                  count_in = count_ff + LW'(1);
                  if (count_ff == '0) begin
                     head_in = LW'(ff_slot);
                     tail_in = LW'(ff_slot);
                     state_in = S_OUT;
                  end else if (op_ff == OP_PUSH_BACK) begin
                     wb_data = tail_ff;
                     tail_in = LW'(ff_slot);
                     cur_in = tail_ff;
                     state_in = S_PLINK;
                  end else begin
                     wf_data = head_ff;
                     head_in = LW'(ff_slot);
                     cur_in = head_ff;
                     state_in = S_PLINK;
                  end
               end
            end
         end
         S_PLINK: begin
            if (op_ff == OP_PUSH_BACK) begin
               wf_en = 1'b1; wf_addr = cur_ff[SW-1:0]; wf_data = LW'(new_ff);
            end else begin
               wb_en = 1'b1; wb_addr = cur_ff[SW-1:0]; wb_data = LW'(new_ff);
            end
            state_in = S_OUT;
         end
         S_RD: begin
            if (cur_ff >= NIL || steps_ff >= LW'(CAPACITY)) begin
               state_in = S_OUT;
            end else begin
               rd_en = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (val_rd_ff == val_ff) begin
               st_in = ST_DONE;
               free_in[cur_ff[SW-1:0]] = 1'b1;
               count_in = count_ff - LW'(1);
               state_in = S_FIXP;
            end else begin
               cur_in = fwd_rd_ff;
               steps_in = steps_ff + LW'(1);
               state_in = S_RD;
            end
         end
         S_FIXP: begin
            // p.next = n, or head = n
            if (bwd_rd_ff < NIL) begin
               wf_en = 1'b1; wf_addr = bwd_rd_ff[SW-1:0]; wf_data = fwd_rd_ff;
            end else begin
               head_in = fwd_rd_ff;
            end
            state_in = S_FIXN;
         end
         S_FIXN: begin
            if (fwd_rd_ff < NIL) begin
               wb_en = 1'b1; wb_addr = fwd_rd_ff[SW-1:0]; wb_data = bwd_rd_ff;
            end else begin
               tail_in = bwd_rd_ff;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wv_en) val_mem[wv_addr] <= val_ff;
      if (wf_en) fwd_mem[wf_addr] <= wf_data;
      if (wb_en) bwd_mem[wb_addr] <= wb_data;
      if (rd_en) begin
         val_rd_ff <= val_mem[rd_addr];
         fwd_rd_ff <= fwd_mem[rd_addr];
         bwd_rd_ff <= bwd_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      val_ff   <= val_in;
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      new_ff   <= new_in;
      st_ff    <= st_in;
      used_ff  <= used_in;
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         count_ff <= '0;
         free_ff  <= '1;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         free_ff  <= free_in;
         rv_ff    <= rv_in;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/olpd_free_find.sv */
// Lowest-free-slot search over the free map, 8 slots per cycle.
// Depends on olpd_pkg.
`default_nettype none
module olpd_free_find
   import olpd_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire find_req_type        req,
   input  wire logic [CAPACITY-1:0] free_map,
   output logic                     done,
   output logic                     found,
   output logic [$clog2(CAPACITY)-1:0] slot
);
   localparam int SW = $clog2(CAPACITY);
   // wide enough for base + 8 past the last group
   localparam int CW = $clog2(CAPACITY + 8);
   logic          busy_ff, busy_in;
   logic [CW-1:0] base_ff, base_in;
   logic          hit;
   logic [SW-1:0] hit_slot;
   logic [CW-1:0] idx;

   always_comb begin
      hit = 1'b0;
      hit_slot = '0;
      for (int k = 7; k >= 0; k--) begin
         idx = base_ff + CW'(k);
         if (idx < CW'(CAPACITY)) begin
            if (free_map[idx[SW-1:0]]) begin
               hit = 1'b1;
               hit_slot = idx[SW-1:0];
            end
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      base_in = base_ff;
      done = 1'b0;
      found = 1'b0;
      slot = hit_slot;
      if (req.start) begin
         busy_in = 1'b1;
         base_in = '0;
      end else if (busy_ff) begin
         if (hit || (base_ff + CW'(8) >= CW'(CAPACITY))) begin
            done = 1'b1;
            found = hit;
            busy_in = 1'b0;
         end else begin
            base_in = base_ff + CW'(8);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         base_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         base_ff <= base_in;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/olpd_checker.sv */
// Port-level checker for the ordered list core, bound to the top level.
// Depends on olpd_pkg and ordered_list_push_delete_core.
`default_nettype none
module olpd_checker
   import olpd_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [39:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);
   // no new word taken while a result waits
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while result pending");
   // count never exceeds the pool size
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:2] <= 7'(CAPACITY)) else $error("count too large");
   // clear always ends with empty list
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[1:0] == OP_CLEAR) |=> ##1
      rsp_tdata[8:2] == 7'd0)
      else $error("clear not empty");
   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata)) else $error("result changed");
endmodule

bind ordered_list_push_delete_core olpd_checker #(.CAPACITY(CAPACITY)) u_olpd_checker (.*);
`default_nettype wire
